>>> src/lss_pkg.sv
// Shared codes and controller/datapath interface types for the line search step block.
package lss_pkg;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXTREM  = 3'd1;
  localparam logic [2:0] ST_BOUND   = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_BADSET  = 3'd4;
  localparam logic [2:0] ST_LIMIT   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_BOUNDA = 3'd1;
  localparam logic [2:0] CFG_BOUNDB = 3'd2;
  localparam logic [2:0] CFG_MAXSTP = 3'd3;
  localparam logic [2:0] CFG_INISTP = 3'd4;

  localparam logic [5:0] LIMIT_LOW   = 6'd2;
  localparam logic [5:0] LIMIT_HIGH  = 6'd50;
  localparam logic [5:0] LIMIT_RESET = 6'd7;
  localparam logic [5:0] COUNT_MAX   = 6'd63;

  // datapath commands
  localparam logic [4:0] C_NONE     = 5'd0;
  localparam logic [4:0] C_LOAD     = 5'd1;
  localparam logic [4:0] C_BRACKET  = 5'd2;
  localparam logic [4:0] C_FALLBACK = 5'd3;
  localparam logic [4:0] C_DIV_DT   = 5'd4;
  localparam logic [4:0] C_WR_Q     = 5'd5;
  localparam logic [4:0] C_MUL_PP   = 5'd6;
  localparam logic [4:0] C_WR_PP    = 5'd7;
  localparam logic [4:0] C_MUL_A    = 5'd8;
  localparam logic [4:0] C_WR_A     = 5'd9;
  localparam logic [4:0] C_MUL_B    = 5'd10;
  localparam logic [4:0] C_WR_B     = 5'd11;
  localparam logic [4:0] C_MUL_AA   = 5'd12;
  localparam logic [4:0] C_WR_AA    = 5'd13;
  localparam logic [4:0] C_MUL_BPP  = 5'd14;
  localparam logic [4:0] C_WR_DISC  = 5'd15;
  localparam logic [4:0] C_SQRT     = 5'd16;
  localparam logic [4:0] C_WR_C     = 5'd17;
  localparam logic [4:0] C_DIV_PC   = 5'd18;
  localparam logic [4:0] C_MUL_LSDT = 5'd19;
  localparam logic [4:0] C_WR_DTABS = 5'd20;
  localparam logic [4:0] C_MUL_EX   = 5'd21;
  localparam logic [4:0] C_WR_EX    = 5'd22;
  localparam logic [4:0] C_DIV_AB   = 5'd23;
  localparam logic [4:0] C_MUL_DTS  = 5'd24;
  localparam logic [4:0] C_CLAMP    = 5'd25;
  localparam logic [4:0] C_STEP     = 5'd26;
  localparam logic [4:0] C_UPDATE   = 5'd27;
  localparam logic [4:0] C_RESULT   = 5'd28;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] code;
  } lss_cmd_t;

  typedef struct packed {
    logic over;
    logic first;
    logic out_rng;
    logic bad;
    logic ext;
    logic sgn_diff;
    logic f_ge_best;
    logic ab_zero;
    logic c_gt_pp;
    logic ls_zero;
    logic ds_done;
    logic out_busy;
  } lss_stat_t;

endpackage

>>> src/lss_divsqrt.sv
// Shared bit-serial unsigned divider and digit-serial square root unit.
module lss_divsqrt import lss_pkg::*; #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 sqrt_i,
  input  logic [VALUE_WIDTH+FRACTION_BITS-1:0] num_i,
  input  logic [VALUE_WIDTH-1:0]               den_i,
  output logic [VALUE_WIDTH+FRACTION_BITS-1:0] res_o,
  output logic                                 done_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int N  = VALUE_WIDTH + FRACTION_BITS;
  localparam int NP = N + (N % 2);
  localparam int H  = NP / 2;
  localparam int RW = H + 2;
  localparam int CW = $clog2(N);
  localparam logic [CW-1:0] DIV_LAST = CW'(N - 1);
  localparam logic [CW-1:0] SQ_LAST  = CW'(H - 1);

  logic          run_q, done_q, mode_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [N-1:0]  quo_q;
  logic [W-1:0]  den_q;
  logic [NP-1:0] src_q;
  logic [RW-1:0] srem_q;
  logic [H-1:0]  root_q;

  logic [W:0]    rem_sh;
  logic          q_bit;
  logic [RW-1:0] srem_n, trial;
  logic          r_bit;

  // remainder stays below the divisor, so W bits hold it between steps
  assign rem_sh = {rem_q, quo_q[N-1]};
  assign q_bit  = rem_sh >= {1'b0, den_q};
  assign srem_n = {srem_q[RW-3:0], src_q[NP-1:NP-2]};
  assign trial  = {root_q, 2'b01};
  assign r_bit  = srem_n >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        cnt_q  <= '0;
        mode_q <= sqrt_i;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == (mode_q ? SQ_LAST : DIV_LAST)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= num_i;
      den_q  <= den_i;
      src_q  <= NP'(num_i);
      srem_q <= '0;
      root_q <= '0;
    end else if (run_q) begin
      if (!mode_q) begin
        rem_q <= q_bit ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
        quo_q <= {quo_q[N-2:0], q_bit};
      end else begin
        srem_q <= r_bit ? (srem_n - trial) : srem_n;
        root_q <= {root_q[H-2:0], r_bit};
        src_q  <= src_q << 2;
      end
    end
  end

  assign res_o  = mode_q ? N'(root_q) : quo_q;
  assign done_o = done_q;

endmodule

>>> src/lss_ctrl.sv
// Sequencing state machine for one line search step.
module lss_ctrl import lss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      busy_o,
  input  lss_stat_t stat_i,
  output lss_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_RANGE  = 5'd2;
  localparam logic [4:0] S_CDIV   = 5'd3;
  localparam logic [4:0] S_CPP    = 5'd4;
  localparam logic [4:0] S_CPPW   = 5'd5;
  localparam logic [4:0] S_CA     = 5'd6;
  localparam logic [4:0] S_CAW    = 5'd7;
  localparam logic [4:0] S_CB     = 5'd8;
  localparam logic [4:0] S_CBW    = 5'd9;
  localparam logic [4:0] S_CAA    = 5'd10;
  localparam logic [4:0] S_CAAW   = 5'd11;
  localparam logic [4:0] S_CBPP   = 5'd12;
  localparam logic [4:0] S_CDISC  = 5'd13;
  localparam logic [4:0] S_CSQ    = 5'd14;
  localparam logic [4:0] S_CSQW   = 5'd15;
  localparam logic [4:0] S_CCMP   = 5'd16;
  localparam logic [4:0] S_CDIV2  = 5'd17;
  localparam logic [4:0] S_CLS    = 5'd18;
  localparam logic [4:0] S_DTW    = 5'd19;
  localparam logic [4:0] S_EX     = 5'd20;
  localparam logic [4:0] S_EXC    = 5'd21;
  localparam logic [4:0] S_EXDIV  = 5'd22;
  localparam logic [4:0] S_EXM    = 5'd23;
  localparam logic [4:0] S_FCLAMP = 5'd24;
  localparam logic [4:0] S_FSTEP  = 5'd25;
  localparam logic [4:0] S_FUPD   = 5'd26;
  localparam logic [4:0] S_FCHK   = 5'd27;
  localparam logic [4:0] S_RES    = 5'd28;

  logic [4:0] state_q, state_d;
  logic [2:0] code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '{op: C_NONE, code: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = C_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.over) begin
          code_d  = ST_LIMIT;
          state_d = S_RES;
        end else begin
          cmd_o.op = C_BRACKET;
          state_d  = S_RANGE;
        end
      end
      S_RANGE: begin
        if (stat_i.out_rng) begin
          code_d  = ST_RANGE;
          state_d = S_RES;
        end else if (stat_i.first) begin
          if (stat_i.bad) begin
            code_d  = ST_BADSET;
            state_d = S_RES;
          end else begin
            cmd_o.op = C_FALLBACK;
            state_d  = S_FCLAMP;
          end
        end else if (stat_i.ext) begin
          code_d  = ST_EXTREM;
          state_d = S_RES;
        end else if (stat_i.sgn_diff) begin
          cmd_o.op = C_DIV_DT;
          state_d  = S_CDIV;
        end else if (stat_i.f_ge_best) begin
          cmd_o.op = C_FALLBACK;
          state_d  = S_FCLAMP;
        end else begin
          cmd_o.op = C_MUL_EX;
          state_d  = S_EX;
        end
      end
      // cubic fit across the slope sign change
      S_CDIV: begin
        if (stat_i.ds_done) begin
          cmd_o.op = C_WR_Q;
          state_d  = S_CPP;
        end
      end
      S_CPP:   begin cmd_o.op = C_MUL_PP;   state_d = S_CPPW;  end
      S_CPPW:  begin cmd_o.op = C_WR_PP;    state_d = S_CA;    end
      S_CA:    begin cmd_o.op = C_MUL_A;    state_d = S_CAW;   end
      S_CAW:   begin cmd_o.op = C_WR_A;     state_d = S_CB;    end
      S_CB:    begin cmd_o.op = C_MUL_B;    state_d = S_CBW;   end
      S_CBW:   begin cmd_o.op = C_WR_B;     state_d = S_CAA;   end
      S_CAA:   begin cmd_o.op = C_MUL_AA;   state_d = S_CAAW;  end
      S_CAAW:  begin cmd_o.op = C_WR_AA;    state_d = S_CBPP;  end
      S_CBPP:  begin cmd_o.op = C_MUL_BPP;  state_d = S_CDISC; end
      S_CDISC: begin cmd_o.op = C_WR_DISC;  state_d = S_CSQ;   end
      S_CSQ:   begin cmd_o.op = C_SQRT;     state_d = S_CSQW;  end
      S_CSQW: begin
        if (stat_i.ds_done) begin
          cmd_o.op = C_WR_C;
          state_d  = S_CCMP;
        end
      end
      S_CCMP: begin
        if (stat_i.c_gt_pp) begin
          cmd_o.op = C_DIV_PC;
          state_d  = S_CDIV2;
        end else begin
          state_d = S_CLS;
        end
      end
      S_CDIV2: begin
        if (stat_i.ds_done) begin
          cmd_o.op = C_WR_Q;
          state_d  = S_CLS;
        end
      end
      S_CLS:   begin cmd_o.op = C_MUL_LSDT; state_d = S_DTW;   end
      S_DTW:   begin cmd_o.op = C_WR_DTABS; state_d = S_FCLAMP; end
      // sign-based extrapolation
      S_EX:    begin cmd_o.op = C_WR_EX;    state_d = S_EXC;   end
      S_EXC: begin
        if (stat_i.ab_zero) begin
          cmd_o.op = C_FALLBACK;
          state_d  = S_FCLAMP;
        end else begin
          cmd_o.op = C_DIV_AB;
          state_d  = S_EXDIV;
        end
      end
      S_EXDIV: begin
        if (stat_i.ds_done) begin
          cmd_o.op = C_WR_Q;
          state_d  = S_EXM;
        end
      end
      S_EXM:    begin cmd_o.op = C_MUL_DTS; state_d = S_DTW;   end
      S_FCLAMP: begin cmd_o.op = C_CLAMP;   state_d = S_FSTEP; end
      S_FSTEP:  begin cmd_o.op = C_STEP;    state_d = S_FUPD;  end
      S_FUPD:   begin cmd_o.op = C_UPDATE;  state_d = S_FCHK;  end
      S_FCHK: begin
        code_d  = stat_i.ls_zero ? ST_BOUND : ST_OK;
        state_d = S_RES;
      end
      S_RES: begin
        // hold until the output register can take the beat
        if (!stat_i.out_busy) begin
          cmd_o.op   = C_RESULT;
          cmd_o.code = code_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

endmodule

>>> src/lss_dp.sv
// Datapath: settings, search state, working registers, multiplier and result register.
module lss_dp import lss_pkg::*; #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lss_cmd_t                             cmd_i,
  output lss_stat_t                            stat_o,
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]               cfg_data_i,
  input  logic                                 operation_i,
  input  logic signed [VALUE_WIDTH-1:0]        argument_i,
  input  logic signed [VALUE_WIDTH-1:0]        value_i,
  input  logic signed [VALUE_WIDTH-1:0]        slope_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic signed [VALUE_WIDTH-1:0]        next_argument_o,
  output logic [2:0]                           status_o,
  output logic [5:0]                           steps_taken_o,
  output logic                                 ds_start_o,
  output logic                                 ds_sqrt_o,
  output logic [VALUE_WIDTH+FRACTION_BITS-1:0] ds_num_o,
  output logic [VALUE_WIDTH-1:0]               ds_den_o,
  input  logic [VALUE_WIDTH+FRACTION_BITS-1:0] ds_res_i,
  input  logic                                 ds_done_i
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int N  = VALUE_WIDTH + FRACTION_BITS;
  localparam int WX = VALUE_WIDTH + 4;
  localparam int MW = 2 * VALUE_WIDTH + FRACTION_BITS;

  localparam logic signed [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [WX-1:0] XMAX = {4'b0000, VMAX};
  localparam logic signed [WX-1:0] XMIN = {4'b1111, VMIN};
  localparam logic [MW-1:0] MMAX = MW'({1'b0, {(W-1){1'b1}}});
  localparam logic [MW-1:0] MMIN = MW'({1'b1, {(W-1){1'b0}}});

  localparam longint SIXTH_L = ((longint'(1666) << F) + 5000) / 10000;
  localparam longint BA_L    = -(longint'(10) << F);
  localparam longint BB_L    = longint'(10) << F;
  localparam longint MX_L    = longint'(1) << F;
  localparam longint IS_L    = (longint'(655) << F) >> 16;
  localparam logic signed [W-1:0] SIXTH  = W'(SIXTH_L);
  localparam logic signed [W-1:0] BA_RST = W'(BA_L);
  localparam logic signed [W-1:0] BB_RST = W'(BB_L);
  localparam logic signed [W-1:0] MX_RST = W'(MX_L);
  localparam logic signed [W-1:0] IS_RST = W'(IS_L);

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] x);
    mag_f = x[W-1] ? unsigned'(-x) : unsigned'(x);
  endfunction

  function automatic logic signed [W-1:0] fmag_f(input logic neg, input logic [MW-1:0] m);
    if (neg) fmag_f = (m > MMIN) ? VMIN : -$signed(m[W-1:0]);
    else     fmag_f = (m > MMAX) ? VMAX : $signed(m[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] sat_f(input logic signed [WX-1:0] x);
    if (x > XMAX)      sat_f = VMAX;
    else if (x < XMIN) sat_f = VMIN;
    else               sat_f = $signed(x[W-1:0]);
  endfunction

  function automatic logic signed [WX-1:0] ext_f(input logic signed [W-1:0] x);
    ext_f = $signed({{4{x[W-1]}}, x});
  endfunction

  function automatic logic signed [W-1:0] qabs_f(input logic signed [W-1:0] x);
    if (x == VMIN)  qabs_f = VMAX;
    else if (x[W-1]) qabs_f = -x;
    else            qabs_f = x;
  endfunction

  // settings and search state
  logic [5:0]          lim_q, cnt_q;
  logic signed [W-1:0] ba_q, bb_q, mx_q, is_q;
  logic signed [W-1:0] best_q, bs_q, lo_q, hi_q, ls_q;
  logic                ov_q;
  // item and working registers
  logic signed [W-1:0] t_q, f_q, s_q, df_q, dt_q, pp_q, a_q, b_q, aa_q, c_q, p_q;
  logic [2*W-1:0]      prod_q;
  logic                neg_q, dneg_q, dz_q, dan_q;
  logic signed [W-1:0] nxt_q;
  logic [2:0]          st_q;
  logic [5:0]          steps_q;

  logic signed [W-1:0]  qm, qd, mul_x, mul_y, div_x, div_y, p0, step_p, ls_new, root;
  logic signed [WX-1:0] qm_x, df_x, d2, sum_x;
  logic                 down, mul_en, better;
  logic [5:0]           cnt_inc;

  assign down    = !s_q[W-1] && (s_q != '0);
  assign qm      = fmag_f(neg_q, MW'(prod_q >> F));
  assign qm_x    = ext_f(qm);
  assign df_x    = ext_f(df_q);
  assign d2      = qm_x - (df_x <<< 1);
  assign qd      = dz_q ? (dan_q ? VMIN : VMAX) : fmag_f(dneg_q, MW'(ds_res_i));
  assign root    = fmag_f(1'b0, MW'(ds_res_i));
  assign better  = f_q < best_q;
  assign cnt_inc = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + 6'd1;

  assign sum_x  = down ? (ext_f(t_q) - ext_f(dt_q)) : (ext_f(t_q) + ext_f(dt_q));
  assign p0     = sat_f(sum_x);
  assign step_p = down ? ((p0 < lo_q) ? lo_q : p0) : ((p0 > hi_q) ? hi_q : p0);
  assign ls_new = better ? sat_f(ext_f(p_q) - ext_f(t_q))
                         : sat_f(ext_f(p_q) - ext_f(down ? lo_q : hi_q));

  always_comb begin
    mul_en = 1'b1;
    mul_x  = s_q;
    mul_y  = ls_q;
    case (cmd_i.op)
      C_MUL_PP:   begin mul_x = s_q; mul_y = ls_q; end
      C_MUL_A:    begin mul_x = sat_f(ext_f(bs_q) + (ext_f(s_q) <<< 1)); mul_y = ls_q; end
      C_MUL_B:    begin mul_x = sat_f(ext_f(bs_q) + ext_f(s_q)); mul_y = ls_q; end
      C_MUL_AA:   begin mul_x = a_q; mul_y = a_q; end
      C_MUL_BPP:  begin mul_x = b_q; mul_y = pp_q; end
      C_MUL_LSDT: begin mul_x = ls_q; mul_y = dt_q; end
      C_MUL_EX: begin
        mul_x = sat_f(ext_f(s_q) + (ext_f(s_q) <<< 2) - ext_f(bs_q));
        mul_y = ls_q;
      end
      C_MUL_DTS:  begin mul_x = dt_q; mul_y = SIXTH; end
      default:    mul_en = 1'b0;
    endcase
  end

  always_comb begin
    ds_start_o = 1'b1;
    ds_sqrt_o  = 1'b0;
    div_x      = s_q;
    div_y      = sat_f(ext_f(s_q) - ext_f(bs_q));
    case (cmd_i.op)
      C_DIV_DT: ;
      C_DIV_PC: begin div_x = pp_q; div_y = c_q; end
      C_DIV_AB: begin div_x = a_q;  div_y = b_q; end
      C_SQRT:   begin div_x = aa_q; ds_sqrt_o = 1'b1; end
      default:  ds_start_o = 1'b0;
    endcase
  end

  assign ds_num_o = N'(mag_f(div_x)) << F;
  assign ds_den_o = mag_f(div_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= LIMIT_RESET;
      ba_q   <= BA_RST;
      bb_q   <= BB_RST;
      mx_q   <= MX_RST;
      is_q   <= IS_RST;
      cnt_q  <= '0;
      best_q <= VMAX;
      bs_q   <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
      ls_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LIMIT:  lim_q <= cfg_data_i[5:0];
          CFG_BOUNDA: ba_q  <= cfg_data_i;
          CFG_BOUNDB: bb_q  <= cfg_data_i;
          CFG_MAXSTP: mx_q  <= cfg_data_i;
          CFG_INISTP: is_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // a new beat may replace the one leaving in the same cycle
      if (cmd_i.op == C_RESULT)        ov_q <= 1'b1;
      else if (ov_q && !out_stall_i)   ov_q <= 1'b0;
      case (cmd_i.op)
        C_LOAD: if (operation_i) cnt_q <= '0;
        C_BRACKET: begin
          if (cnt_q == '0) begin
            lo_q <= (ba_q > bb_q) ? bb_q : ba_q;
            hi_q <= (ba_q > bb_q) ? ba_q : bb_q;
          end
        end
        C_FALLBACK: best_q <= VMAX;
        C_UPDATE: begin
          ls_q <= ls_new;
          if (better) begin
            best_q <= f_q;
            bs_q   <= s_q;
            if (down) hi_q <= t_q;
            else      lo_q <= t_q;
          end
        end
        C_RESULT: begin
          if (cmd_i.code == ST_OK) cnt_q <= cnt_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= (2*W)'(mag_f(mul_x)) * (2*W)'(mag_f(mul_y));
      neg_q  <= mul_x[W-1] ^ mul_y[W-1];
    end
    if (ds_start_o) begin
      dneg_q <= div_x[W-1] ^ div_y[W-1];
      dz_q   <= div_y == '0;
      dan_q  <= div_x[W-1];
    end
    case (cmd_i.op)
      C_LOAD: begin
        t_q <= argument_i;
        f_q <= value_i;
        s_q <= slope_i;
      end
      C_BRACKET:  df_q <= sat_f(ext_f(f_q) - ext_f(best_q));
      C_FALLBACK: dt_q <= is_q;
      C_WR_Q:     dt_q <= qd;
      C_WR_PP:    pp_q <= qm;
      C_WR_A:     a_q  <= sat_f(qm_x - (df_x + (df_x <<< 1)));
      C_WR_B:     b_q  <= sat_f(d2 + (d2 <<< 1));
      C_WR_AA:    aa_q <= qm;
      C_WR_DISC:  aa_q <= qabs_f(sat_f(ext_f(aa_q) - qm_x));
      C_WR_C:     c_q  <= qabs_f(sat_f(ext_f(a_q) + ext_f(root)));
      C_WR_DTABS: dt_q <= qabs_f(qm);
      C_WR_EX: begin
        a_q <= sat_f((df_x <<< 1) + qm_x);
        b_q <= sat_f(ext_f(bs_q) - ext_f(s_q));
      end
      C_CLAMP: if (dt_q > mx_q) dt_q <= mx_q;
      C_STEP:  p_q <= step_p;
      C_RESULT: begin
        st_q    <= cmd_i.code;
        nxt_q   <= (cmd_i.code == ST_OK) ? p_q : '0;
        steps_q <= (cmd_i.code == ST_OK) ? cnt_inc : cnt_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.over      = cnt_q > lim_q;
    stat_o.first     = cnt_q == '0;
    stat_o.out_rng   = (t_q < lo_q) || (t_q > hi_q);
    stat_o.bad       = !(lim_q inside {[LIMIT_LOW:LIMIT_HIGH]}) ||
                       mx_q[W-1] || (mx_q == '0) || is_q[W-1] || (is_q == '0);
    stat_o.ext       = (s_q == '0) || (bs_q == '0);
    stat_o.sgn_diff  = s_q[W-1] != bs_q[W-1];
    stat_o.f_ge_best = f_q >= best_q;
    stat_o.ab_zero   = (a_q == '0) || (b_q == '0);
    stat_o.c_gt_pp   = c_q > qabs_f(pp_q);
    stat_o.ls_zero   = ls_q == '0;
    stat_o.ds_done   = ds_done_i;
    stat_o.out_busy  = ov_q && out_stall_i;
  end

  assign out_valid_o     = ov_q;
  assign next_argument_o = nxt_q;
  assign status_o        = st_q;
  assign steps_taken_o   = steps_q;

endmodule

>>> src/line_search_step.sv
// Top level of the line search step block: controller, datapath and divide/root unit.
// One item in flight at a time. A cubic step uses one or two divides and a square root,
// an extrapolation step at most one divide, and a start or fallback step none. The
// shared divide/root unit sets the pace of the long steps (default format Q16.16): it
// retires one quotient bit or one root digit per cycle. Status exits (limit, range,
// settings, extremum) go straight to the result. The result register lets the next
// beat enter while a result waits to be taken.
module line_search_step import lss_pkg::*; #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [VALUE_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic signed [VALUE_WIDTH-1:0] argument_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic signed [VALUE_WIDTH-1:0] slope_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] next_argument_o,
  output logic [2:0]                    status_o,
  output logic [5:0]                    steps_taken_o
);

  localparam int N = VALUE_WIDTH + FRACTION_BITS;

  lss_cmd_t               cmd;
  lss_stat_t              stat;
  logic                   ds_start, ds_sqrt, ds_done;
  logic [N-1:0]           ds_num, ds_res;
  logic [VALUE_WIDTH-1:0] ds_den;

  lss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lss_dp #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .argument_i      (argument_i),
    .value_i         (value_i),
    .slope_i         (slope_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .next_argument_o (next_argument_o),
    .status_o        (status_o),
    .steps_taken_o   (steps_taken_o),
    .ds_start_o      (ds_start),
    .ds_sqrt_o       (ds_sqrt),
    .ds_num_o        (ds_num),
    .ds_den_o        (ds_den),
    .ds_res_i        (ds_res),
    .ds_done_i       (ds_done)
  );

  lss_divsqrt #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .sqrt_i  (ds_sqrt),
    .num_i   (ds_num),
    .den_i   (ds_den),
    .res_o   (ds_res),
    .done_o  (ds_done)
  );

endmodule

>>> src/lss_chk.sv
// Port-level checker for the line search step block, bound to the top level.
module lss_chk import lss_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [VALUE_WIDTH-1:0] next_argument_o,
  input logic [2:0]                    status_o,
  input logic [5:0]                    steps_taken_o
);

  // a result beat held by the receiver stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // and its payload does not move
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(next_argument_o) && $stable(status_o) && $stable(steps_taken_o))
    else $error("result payload changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_LIMIT))
    else $error("status code out of range");

  a_next_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (next_argument_o == '0))
    else $error("next argument not zero on failed step");

  // one item at a time: an accepted beat closes the input side
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

endmodule

bind line_search_step lss_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_lss_chk (.*);

>>> verif/tb_line_search_step.sv
// Testbench for line_search_step: reference predictor in a scoreboard, randomized beats and stalls.
module tb_line_search_step;
  import lss_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint SIXTH = ((64'd1666 << 16) + 64'd5000) / 64'd10000;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] next_arg;
    logic [2:0]  status;
    logic [5:0]  steps;
  } step_result_t;

  class step_scoreboard;
    bit [5:0] iter_limit;
    longint bound_a, bound_b, max_step, init_step;
    bit [5:0] count;
    longint best_value, best_slope, br_low, br_high, last_step;
    step_result_t pending_q[$];
    int errors;
    longint last_next;
    bit last_ok;

    function new();
      iter_limit = LIMIT_RESET;
      bound_a = -655360; bound_b = 655360; max_step = 65536; init_step = 655;
      count = 0; best_value = VMAX; best_slope = 0; br_low = 0; br_high = 0;
      last_step = 0; errors = 0; last_next = 0; last_ok = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_LIMIT:  iter_limit = data[5:0];
        CFG_BOUNDA: bound_a = longint'($signed(data));
        CFG_BOUNDB: bound_b = longint'($signed(data));
        CFG_MAXSTP: max_step = longint'($signed(data));
        CFG_INISTP: init_step = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function longint sat(longint x);
      if (x > VMAX) return VMAX;
      if (x < VMIN) return VMIN;
      return x;
    endfunction

    function longint unsigned mag(longint x);
      return x < 0 ? longint'(-x) : x;
    endfunction

    function longint from_mag(bit neg, longint unsigned m);
      if (neg) return (m > 64'd2147483648) ? VMIN : -longint'(m);
      return (m > 64'd2147483647) ? VMAX : longint'(m);
    endfunction

    function longint qmul(longint a, longint b);
      return from_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> 16);
    endfunction

    function longint qdiv(longint a, longint b);
      if (b == 0) return a < 0 ? VMIN : VMAX;
      return from_mag((a < 0) != (b < 0), (mag(a) << 16) / mag(b));
    endfunction

    function longint qsqrt(longint a);
      longint unsigned n, r, b;
      n = mag(a) << 16; r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return from_mag(1'b0, r);
    endfunction

    function longint qabs(longint a);
      return sat(a < 0 ? -a : a);
    endfunction

    function void push(longint nxt, logic [2:0] st);
      step_result_t r;
      r.next_arg = nxt[31:0]; r.status = st; r.steps = count;
      pending_q.push_back(r);
      last_ok = (st == ST_OK);
      if (last_ok) last_next = nxt;
    endfunction

    // predict the result of one accepted input beat
    function void note_beat(logic op, logic [31:0] arg, logic [31:0] val, logic [31:0] slp);
      longint t, f, s, dt, p, df, pp, a, b, c, disc;
      bit fallback, down;
      t = longint'($signed(arg)); f = longint'($signed(val)); s = longint'($signed(slp));
      fallback = 0; dt = 0;
      if (op) count = 0;
      if (count > iter_limit) begin push(0, ST_LIMIT); return; end
      if (count == 0) begin
        if (bound_a > bound_b) begin br_low = bound_b; br_high = bound_a; end
        else begin br_low = bound_a; br_high = bound_b; end
      end
      if (t < br_low || t > br_high) begin push(0, ST_RANGE); return; end
      if (count == 0) begin
        if (iter_limit < LIMIT_LOW || iter_limit > LIMIT_HIGH || max_step <= 0 ||
            init_step <= 0) begin
          push(0, ST_BADSET); return;
        end
        fallback = 1;
      end else begin
        df = sat(f - best_value);
        if (s == 0 || best_slope == 0) begin push(0, ST_EXTREM); return; end
        if ((s < 0) != (best_slope < 0)) begin
          // cubic fit across the slope sign change
          dt = qdiv(s, sat(s - best_slope));
          pp = qmul(s, last_step);
          a = sat(qmul(sat(best_slope + 2 * s), last_step) - 3 * df);
          b = sat(3 * (qmul(sat(best_slope + s), last_step) - 2 * df));
          disc = qabs(sat(qmul(a, a) - qmul(b, pp)));
          c = qabs(sat(a + qsqrt(disc)));
          if (c > qabs(pp)) dt = qdiv(pp, c);
          dt = qabs(qmul(last_step, dt));
        end else if (f >= best_value) begin
          fallback = 1;
        end else begin
          a = sat(2 * df + qmul(sat(5 * s - best_slope), last_step));
          b = sat(best_slope - s);
          if (a == 0 || b == 0) fallback = 1;
          else dt = qabs(qmul(qdiv(a, b), SIXTH));
        end
      end
      if (fallback) begin
        dt = init_step; best_value = VMAX;
      end
      if (dt > max_step) dt = max_step;
      down = s > 0;
      if (down) begin
        p = sat(t - dt);
        if (p < br_low) p = br_low;
      end else begin
        p = sat(t + dt);
        if (p > br_high) p = br_high;
      end
      if (f < best_value) begin
        best_value = f; best_slope = s; last_step = sat(p - t);
        if (down) br_high = t; else br_low = t;
      end else begin
        last_step = sat(p - (down ? br_low : br_high));
      end
      if (last_step == 0) begin push(0, ST_BOUND); return; end
      if (count < COUNT_MAX) count++;
      push(p, ST_OK);
    endfunction

    function void check_beat(logic [31:0] nxt, logic [2:0] st, logic [5:0] steps);
      step_result_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (nxt !== e.next_arg) begin
        $error("next_argument: expected %h actual %h", e.next_arg, nxt); errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, st); errors++;
      end
      if (steps !== e.steps) begin
        $error("steps_taken: expected %0d actual %0d", e.steps, steps); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = CFG_LIMIT;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic signed [31:0] argument_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] slope_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] next_argument_o;
  logic [2:0] status_o;
  logic [5:0] steps_taken_o;

  step_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  logic [31:0] prev_value = 32'sd100000;

  line_search_step dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else out_stall_i = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat(next_argument_o, status_o, steps_taken_o);

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send_beat(logic op, logic [31:0] arg, logic [31:0] val, logic [31:0] slp);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1; operation_i = op; argument_i = arg; value_i = val; slope_i = slp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(op, arg, val, slp);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_slope();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return $urandom();
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(1) ? $urandom_range(200000, 1)
                                         : -$urandom_range(200000, 1);
    endcase
  endfunction

  // mostly follows the proposed argument; some starts and some noise
  task automatic random_beat();
    logic op;
    logic [31:0] arg, val;
    longint span;
    op = ($urandom_range(99) < 8) || !sb.last_ok && ($urandom_range(1) == 0);
    span = sb.br_high - sb.br_low;
    if (!op && sb.last_ok && $urandom_range(99) < 85) arg = sb.last_next[31:0];
    else if ($urandom_range(99) < 10) arg = $urandom();
    else if (span > 0 && span < 64'd4294967295)
      arg = 32'(sb.br_low + longint'($urandom_range(int'(span > 64'd2000000000 ?
            64'd2000000000 : span))));
    else arg = $urandom_range(131072);
    case ($urandom_range(9))
      0: val = $urandom();
      1: val = 32'h7fffffff;
      2, 3: val = prev_value + $urandom_range(50000);
      default: val = prev_value - $urandom_range(50000);
    endcase
    prev_value = op ? 32'sd100000 : val;
    send_beat(op, arg, val, rand_slope());
  endtask

  task automatic run_phase(int n, int idle, int stall);
    idle_pct = idle; stall_pct = stall;
    repeat (n) random_beat();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: start, extrapolation, cubic, fallback, extremum, range, max value
    send_beat(1'b1, 32'sd0, 32'sd200000, 32'sd65536);
    send_beat(1'b0, sb.last_next[31:0], 32'sd150000, 32'sd30000);
    send_beat(1'b0, sb.last_next[31:0], 32'sd140000, -32'sd20000);
    send_beat(1'b0, sb.last_next[31:0], 32'sd900000, -32'sd5000);
    send_beat(1'b0, sb.last_next[31:0], 32'h7fffffff, 32'sd1000);
    send_beat(1'b0, 32'sd0, 32'sd1000, 32'sd0);
    send_beat(1'b0, 32'h7fffffff, 32'sd0, 32'sd1);
    send_beat(1'b0, 32'h80000000, 32'h80000000, 32'h80000000);
    repeat (9) send_beat(1'b0, 32'sd0, 32'sd0, 32'sd100);
    // boundary: at the low bracket end moving down, then at the high end moving up
    send_beat(1'b1, -32'sd655360, 32'sd0, 32'sd100);
    send_beat(1'b1, 32'sd655360, 32'sd0, -32'sd100);
    drain();

    // swapped bounds, smallest legal limit, tiny steps
    write_reg(CFG_LIMIT, 32'd2);
    write_reg(CFG_BOUNDA, 32'sd131072);
    write_reg(CFG_BOUNDB, -32'sd131072);
    write_reg(CFG_MAXSTP, 32'sd1);
    write_reg(CFG_INISTP, 32'sd1);
    run_phase(120, 0, 0);
    drain();

    // widest interval, largest legal limit, large steps
    write_reg(CFG_LIMIT, 32'd50);
    write_reg(CFG_BOUNDA, 32'h80000000);
    write_reg(CFG_BOUNDB, 32'h7fffffff);
    write_reg(CFG_MAXSTP, 32'h7fffffff);
    write_reg(CFG_INISTP, 32'sd65536);
    run_phase(250, 45, 0);
    // sender waits for every result, then the receiver holds off a long time
    drain();
    hold_left = 400;
    run_phase(30, 0, 0);
    drain();

    // max_step made negative in the middle of a search
    write_reg(CFG_MAXSTP, -32'sd70000);
    run_phase(40, 0, 45);
    drain();

    // bad settings: limits outside the legal range, non-positive steps
    write_reg(CFG_LIMIT, 32'd63);
    run_phase(30, 28, 28);
    drain();
    write_reg(CFG_LIMIT, 32'd1);
    write_reg(CFG_MAXSTP, 32'sd65536);
    write_reg(CFG_INISTP, 32'h80000000);
    run_phase(30, 0, 0);
    drain();
    write_reg(CFG_LIMIT, 32'd0);
    write_reg(CFG_INISTP, 32'sd0);
    run_phase(20, 0, 0);
    drain();
    write_reg(CFG_LIMIT, 32'd51);
    write_reg(CFG_INISTP, 32'sd655);
    run_phase(20, 0, 0);
    drain();

    // reset-like settings with mixed idling and stalls
    write_reg(CFG_LIMIT, 32'd7);
    write_reg(CFG_BOUNDA, -32'sd655360);
    write_reg(CFG_BOUNDB, 32'sd655360);
    write_reg(CFG_MAXSTP, 32'sd65536);
    write_reg(CFG_INISTP, 32'sd655);
    run_phase(200, 0, 0);
    run_phase(200, 45, 0);
    run_phase(200, 0, 45);
    run_phase(200, 28, 28);
    drain();

    write_reg(CFG_LIMIT, 32'd20);
    write_reg(CFG_BOUNDA, 32'sd0);
    write_reg(CFG_BOUNDB, 32'sd6553600);
    write_reg(CFG_MAXSTP, 32'sd300000);
    write_reg(CFG_INISTP, 32'sd20000);
    run_phase(100, 28, 28);
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

>>> filelist.f
src/lss_pkg.sv
src/lss_divsqrt.sv
src/lss_ctrl.sv
src/lss_dp.sv
src/line_search_step.sv
src/lss_chk.sv
verif/tb_line_search_step.sv
